[rtl/core/ncdf_pkg.sv]
// ----------------------------------------------------------------------------
// ncdf_pkg: shared constants and helpers for the normal CDF pipeline
// Fixed-point work format is Q.30 with constants rounded to that grid.
// ----------------------------------------------------------------------------
`default_nettype none
package ncdf_pkg;

  localparam int WORK_BITS = 30;
  localparam logic [30:0] W_ONE  = 31'h4000_0000;
  localparam logic [29:0] W_HALF = 30'h2000_0000;

  localparam logic [29:0] INV_SQRT2 = 30'd759250125;
  localparam logic [28:0] P_COEF    = 29'd351748265;

  // Horner coefficients, highest order first
  localparam logic signed [35:0] A5 = 36'sd1139675401;
  localparam logic signed [35:0] HORNER_C [5] = '{
    -36'sd1560310108, 36'sd1526231383, -36'sd305476044, 36'sd273621191, 36'sd0
  };

  // exp(-1,-2,-4,-8,-16) then exp(-1/2,-1/4,-1/8,-1/16), Q.30
  localparam int EXP_TAB_N = 9;
  localparam logic [30:0] EXP_TAB [EXP_TAB_N] = '{
    31'd395007542, 31'd145315154, 31'd19666268, 31'd360200, 31'd121,
    31'd651257337, 31'd836230973, 31'd947573834, 31'd1008687096
  };

  // Taylor steps k = 5..1: divide by k as multiply by ceil(2^31 / k), shift 31
  localparam logic [2:0]  TAY_K [5] = '{3'd5, 3'd4, 3'd3, 3'd2, 3'd1};
  localparam logic [31:0] TAY_M [5] = '{
    32'd429496730, 32'd536870912, 32'd715827883, 32'd1073741824, 32'd2147483648
  };

  // Pipeline depths
  localparam int FRONT_LAT = 5;
  localparam int DIV_LAT   = 31;
  localparam int EXP_LAT   = 16;
  localparam int POLY_LAT  = 10;
  localparam int E_DLY     = DIV_LAT + POLY_LAT - EXP_LAT;
  localparam int NEG_DLY   = DIV_LAT + POLY_LAT + 1;

  typedef struct packed {
    logic        neg;
    logic [31:0] den;
    logic [35:0] q;
  } front_t;

  // Unsigned Q.30 product, rounded to nearest
  function automatic logic [30:0] mul_u31(input logic [30:0] a, input logic [30:0] b);
    logic [62:0] p;
    p = 63'(a) * 63'(b) + 63'(W_HALF);
    return p[60:30];
  endfunction

endpackage
`default_nettype wire

[rtl/core/ncdf_front.sv]
// ----------------------------------------------------------------------------
// ncdf_front: argument conditioning
// Takes |x|, scales by 1/sqrt2, forms the divisor 1 + p*s and the square s*s.
// ----------------------------------------------------------------------------
`default_nettype none
module ncdf_front import ncdf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic signed [19:0] x_value,
  output logic                    out_valid,
  output front_t                  out_data
);

  localparam logic [28:0] LIM = 29'(8) << FRAC_BITS;

  logic [4:0]  v_r;
  logic [4:0]  neg_r;
  logic [19:0] mag_r;
  logic [49:0] prod_r;
  logic [32:0] s_r;
  logic [61:0] sp_r;
  logic [59:0] lolo_r;
  logic [2:0]  hi_r;
  logic [29:0] lo_r;
  logic [31:0] den_r;
  logic [35:0] q_r;

  logic [19:0] raw;
  logic [19:0] mag_full;
  logic [19:0] mag_nxt;
  logic [32:0] s_nxt;
  logic [31:0] den_nxt;
  logic [35:0] q_nxt;

  // Magnitude with saturation at 8.0
  always_comb begin
    raw      = $unsigned(x_value);
    mag_full = raw[19] ? 20'(~raw + 20'd1) : raw;
    mag_nxt  = ({9'd0, mag_full} > LIM) ? 20'(LIM) : mag_full;
  end

  // Round s to Q.30, then divisor and square
  always_comb begin
    s_nxt   = 33'((51'(prod_r) + (51'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
    den_nxt = 32'(W_ONE) + 32'((63'(sp_r) + 63'(W_HALF)) >> WORK_BITS);
    q_nxt   = ((36'(hi_r) * 36'(hi_r)) << WORK_BITS)
            + ((36'(hi_r) * 36'(lo_r)) << 1)
            + 36'((61'(lolo_r) + 61'(W_HALF)) >> WORK_BITS);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      neg_r  <= {neg_r[3:0], x_value[19]};
      mag_r  <= mag_nxt;
      prod_r <= 50'(mag_r) * 50'(INV_SQRT2);
      s_r    <= s_nxt;
      sp_r   <= 62'(s_r) * 62'(P_COEF);
      lolo_r <= 60'(s_r[29:0]) * 60'(s_r[29:0]);
      hi_r   <= s_r[32:30];
      lo_r   <= s_r[29:0];
      den_r  <= den_nxt;
      q_r    <= q_nxt;
    end
  end

  assign out_valid     = v_r[4];
  assign out_data.neg  = neg_r[4];
  assign out_data.den  = den_r;
  assign out_data.q    = q_r;

endmodule
`default_nettype wire

[rtl/core/ncdf_div.sv]
// ----------------------------------------------------------------------------
// ncdf_div: pipelined reciprocal
// Restoring division t = round(2^60 / den), one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module ncdf_div import ncdf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [31:0] in_den,
  output logic             out_valid,
  output logic [30:0]      out_t
);

  typedef struct packed {
    logic [31:0] den;
    logic [31:0] rem;
    logic [30:0] quo;
  } div_st_t;

  logic    v_r  [DIV_LAT];
  div_st_t st_r [DIV_LAT];

  for (genvar j = 0; j < DIV_LAT; j++) begin : g_stage
    div_st_t     src;
    logic        src_v;
    div_st_t     nxt;
    logic [32:0] trial;

    // Numerator is 2^60 + den/2: high part 2^29, low bits taken from den
    if (j == 0) begin : g_first
      assign src.den = in_den;
      assign src.rem = 32'(W_HALF);
      assign src.quo = '0;
      assign src_v   = in_valid;
    end else begin : g_next
      assign src   = st_r[j-1];
      assign src_v = v_r[j-1];
    end

    // Shift in one numerator bit, subtract when it fits
    always_comb begin
      trial   = {src.rem, src.den[DIV_LAT - j]};
      nxt.den = src.den;
      if (trial >= {1'b0, src.den}) begin
        nxt.rem = 32'(trial - {1'b0, src.den});
        nxt.quo = {src.quo[29:0], 1'b1};
      end else begin
        nxt.rem = trial[31:0];
        nxt.quo = {src.quo[29:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[j] <= nxt;
      end
    end
  end

  assign out_valid = v_r[DIV_LAT-1];
  assign out_t     = st_r[DIV_LAT-1].quo;

endmodule
`default_nettype wire

[rtl/core/ncdf_exp.sv]
// ----------------------------------------------------------------------------
// ncdf_exp: pipelined exp(-q)
// Range reduction by tabled factors alongside a fifth-order Taylor tail.
// ----------------------------------------------------------------------------
`default_nettype none
module ncdf_exp import ncdf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [35:0] in_q,
  output logic             out_valid,
  output logic [30:0]      out_e
);

  localparam int NSTG = EXP_LAT - 1;

  typedef struct packed {
    logic        zero;
    logic [8:0]  sel;
    logic [25:0] r;
    logic [30:0] e;
    logic [59:0] acc;
  } exp_st_t;

  logic    v_r  [NSTG];
  exp_st_t st_r [NSTG];
  logic    out_v_r;
  logic [30:0] out_e_r;

  for (genvar j = 0; j < NSTG; j++) begin : g_stage
    localparam int PHASE = j % 3;
    localparam int STEP  = j / 3;
    localparam int TI    = (j < EXP_TAB_N) ? j : 0;
    exp_st_t     src;
    logic        src_v;
    exp_st_t     nxt;
    logic [27:0] y;

    // Split q: exponent too large, integer and fraction select bits, tail
    if (j == 0) begin : g_first
      assign src.zero = in_q[35];
      assign src.sel  = {in_q[26], in_q[27], in_q[28], in_q[29], in_q[34:30]};
      assign src.r    = in_q[25:0];
      assign src.e    = W_ONE;
      assign src.acc  = 60'(W_ONE);
      assign src_v    = in_valid;
    end else begin : g_next
      assign src   = st_r[j-1];
      assign src_v = v_r[j-1];
    end

    // Tabled factor step and one Taylor phase
    always_comb begin
      nxt = src;
      y   = '0;
      if ((j < EXP_TAB_N) && src.sel[TI]) begin
        nxt.e = mul_u31(src.e, EXP_TAB[TI]);
      end
      if (PHASE == 0) begin
        nxt.acc = 60'(src.r) * 60'(src.acc[30:0]);
      end else if (PHASE == 1) begin
        y       = 28'((src.acc + (60'(TAY_K[STEP]) << 29)) >> WORK_BITS);
        nxt.acc = 60'(y) * 60'(TAY_M[STEP]);
      end else begin
        nxt.acc = 60'(W_ONE) - (src.acc >> 31);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[j] <= nxt;
      end
    end
  end

  // Combine factor product with Taylor tail; drop to zero for large q
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_e_r <= st_r[NSTG-1].zero ? '0
               : mul_u31(st_r[NSTG-1].e, st_r[NSTG-1].acc[30:0]);
    end
  end

  assign out_valid = out_v_r;
  assign out_e     = out_e_r;

endmodule
`default_nettype wire

[rtl/core/ncdf_poly.sv]
// ----------------------------------------------------------------------------
// ncdf_poly: Horner polynomial in t
// Five signed multiply-round-add steps, two stages each, clamped to [0, 2].
// ----------------------------------------------------------------------------
`default_nettype none
module ncdf_poly import ncdf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [30:0] in_t,
  output logic             out_valid,
  output logic [31:0]      out_poly
);

  localparam logic signed [35:0] POLY_MAX = 36'sd2147483648;

  typedef struct packed {
    logic [30:0]        t;
    logic signed [35:0] acc;
    logic [65:0]        prod;
    logic               sgn;
  } poly_st_t;

  logic     v_r  [POLY_LAT];
  poly_st_t st_r [POLY_LAT];

  for (genvar j = 0; j < POLY_LAT; j++) begin : g_stage
    localparam int PHASE = j % 2;
    localparam int STEP  = j / 2;
    poly_st_t           src;
    logic               src_v;
    poly_st_t           nxt;
    logic [34:0]        ua;
    logic [34:0]        p;
    logic signed [35:0] sp;
    logic signed [35:0] sum;

    if (j == 0) begin : g_first
      assign src.t    = in_t;
      assign src.acc  = A5;
      assign src.prod = '0;
      assign src.sgn  = 1'b0;
      assign src_v    = in_valid;
    end else begin : g_next
      assign src   = st_r[j-1];
      assign src_v = v_r[j-1];
    end

    // Multiply magnitude by t, or round, restore sign and add coefficient
    always_comb begin
      nxt = src;
      ua  = '0;
      p   = '0;
      sp  = '0;
      sum = '0;
      if (PHASE == 0) begin
        nxt.sgn  = src.acc[35];
        ua       = src.acc[35] ? 35'(-src.acc) : 35'(src.acc);
        nxt.prod = 66'(ua) * 66'(src.t);
      end else begin
        p   = 35'((67'(src.prod) + 67'(W_HALF)) >> WORK_BITS);
        sp  = src.sgn ? -$signed({1'b0, p}) : $signed({1'b0, p});
        sum = sp + HORNER_C[STEP];
        if (STEP == 4) begin
          if (sum < 0) begin
            sum = '0;
          end else if (sum > POLY_MAX) begin
            sum = POLY_MAX;
          end
        end
        nxt.acc = sum;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[j] <= nxt;
      end
    end
  end

  assign out_valid = v_r[POLY_LAT-1];
  assign out_poly  = st_r[POLY_LAT-1].acc[31:0];

endmodule
`default_nettype wire

[rtl/core/normal_cdf_approx.sv]
// ----------------------------------------------------------------------------
// normal_cdf_approx: standard normal CDF, Q4.16 in, Q1.16 out
// Pipeline depth: 48 register stages from request to out_valid.
// Throughput: one request per cycle; the whole pipeline holds while a result
// waits at the output register and out_ready is low.
// Reset clears only the valid bits; no memories, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module normal_cdf_approx import ncdf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [19:0] in_x_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [16:0]             out_cdf_value
);

  logic        pipe_en;
  logic        front_v;
  front_t      front_d;
  logic        div_v;
  logic [30:0] div_t;
  logic        exp_v;
  logic [30:0] exp_e;
  logic        poly_v;
  logic [31:0] poly_d;

  logic [30:0] e_dly_r   [E_DLY];
  logic        neg_dly_r [NEG_DLY];
  logic        m_v_r;
  logic [62:0] m_prod_r;
  logic        out_valid_r;
  logic [16:0] out_cdf_value_r;

  logic [33:0] m_full;
  logic [30:0] m;
  logic [25:0] half_m;
  logic [25:0] cdf;
  logic [16:0] cdf_nxt;

  // Advance whenever the output register is free or being drained
  assign pipe_en  = !out_valid_r || out_ready;
  assign in_ready = pipe_en && rst_n;

  ncdf_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .en(pipe_en),
    .in_valid(in_valid), .x_value(in_x_value),
    .out_valid(front_v), .out_data(front_d)
  );

  ncdf_div u_div (
    .clk(clk), .rst_n(rst_n), .en(pipe_en),
    .in_valid(front_v), .in_den(front_d.den),
    .out_valid(div_v), .out_t(div_t)
  );

  ncdf_exp u_exp (
    .clk(clk), .rst_n(rst_n), .en(pipe_en),
    .in_valid(front_v), .in_q(front_d.q),
    .out_valid(exp_v), .out_e(exp_e)
  );

  ncdf_poly u_poly (
    .clk(clk), .rst_n(rst_n), .en(pipe_en),
    .in_valid(div_v), .in_t(div_t),
    .out_valid(poly_v), .out_poly(poly_d)
  );

  // Align exp result and sign with the polynomial
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      e_dly_r[0]   <= exp_v ? exp_e : '0;
      neg_dly_r[0] <= front_d.neg;
      for (int i = 1; i < E_DLY; i++) begin
        e_dly_r[i] <= e_dly_r[i-1];
      end
      for (int i = 1; i < NEG_DLY; i++) begin
        neg_dly_r[i] <= neg_dly_r[i-1];
      end
    end
  end

  // Round m, halve at output precision, fold by sign, saturate
  always_comb begin
    m_full = 34'((64'(m_prod_r) + 64'(W_HALF)) >> WORK_BITS);
    m      = (m_full > 34'(W_ONE)) ? W_ONE : m_full[30:0];
    half_m = 26'((32'(m) + (32'(1) << (WORK_BITS - FRAC_BITS)))
                 >> (WORK_BITS + 1 - FRAC_BITS));
    cdf    = neg_dly_r[NEG_DLY-1] ? half_m : ((26'(1) << FRAC_BITS) - half_m);
    cdf_nxt = (cdf > 26'h1FFFF) ? 17'h1FFFF : cdf[16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      m_v_r       <= poly_v;
      out_valid_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m_prod_r        <= 63'(poly_d) * 63'(e_dly_r[E_DLY-1]);
      out_cdf_value_r <= cdf_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cdf_value = out_cdf_value_r;

endmodule
`default_nettype wire

[sim/tb_normal_cdf_approx.sv]
// ----------------------------------------------------------------------------
// tb_normal_cdf_approx: self-checking bench for the normal CDF pipeline
// Drives Q4.16 requests with bursty gaps, stalls the result side on its own
// pattern, and checks every result against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_normal_cdf_approx;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int WB = 30;
  localparam longint ONE = 64'd1 << WB;
  localparam longint HALF = 64'd1 << (WB - 1);
  localparam int LAT = 48;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [19:0] in_x_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [16:0] out_cdf_value;

  normal_cdf_approx #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_x_value(in_x_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_cdf_value(out_cdf_value)
  );

  always #5 clk = ~clk;

  logic [19:0] pending_x[$];
  logic [16:0] expected_cdf[$];
  int mismatches = 0;
  bit stim_done = 1'b0;
  bit long_hold = 1'b0;
  bit drain_req = 1'b0;
  bit drained = 1'b0;
  bit in_acc = 1'b0;

  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b + HALF) >> WB;
  endfunction

  function automatic longint qmul_s(longint a, longint unsigned b);
    longint unsigned ua, p;
    ua = (a < 0) ? longint'(-a) : a;
    p = (ua * b + HALF) >> WB;
    return (a < 0) ? -longint'(p) : longint'(p);
  endfunction

  // exp(-q), q in Q.30: table factors for the upper bits, Taylor for the rest
  function automatic longint unsigned exp_neg_q30(longint unsigned q);
    longint unsigned int_tab[5] = '{395007542, 145315154, 19666268, 360200, 121};
    longint unsigned frac_tab[4] = '{651257337, 836230973, 947573834, 1008687096};
    longint unsigned e, n, r, h;
    if (q >= (longint'(32) << WB)) return 0;
    e = ONE;
    n = q >> WB;
    for (int i = 0; i < 5; i++) if (n[i]) e = qmul(e, int_tab[i]);
    for (int i = 0; i < 4; i++) if (q[WB - 1 - i]) e = qmul(e, frac_tab[i]);
    r = q & ((64'd1 << (WB - 4)) - 1);
    h = ONE;
    for (int k = 5; k >= 1; k--) h = ONE - (r * h + k * HALF) / (k * ONE);
    return qmul(e, h);
  endfunction

  function automatic logic [16:0] phi_of(logic [19:0] raw);
    longint unsigned mag, s, den, t, hi, lo, q, e, m, hm, cdf;
    longint poly;
    bit neg;
    neg = raw[19];
    mag = neg ? (64'h100000 - raw) : raw;
    if (mag > (64'd8 << FRAC)) mag = 64'd8 << FRAC;
    s = ((mag << (WB - FRAC)) * 759250125 + HALF) >> WB;
    den = ONE + ((s * 351748265 + HALF) >> WB);
    t = ((ONE << WB) + den / 2) / den;
    poly = 1139675401;
    poly = -1560310108 + qmul_s(poly, t);
    poly = 1526231383 + qmul_s(poly, t);
    poly = -305476044 + qmul_s(poly, t);
    poly = 273621191 + qmul_s(poly, t);
    poly = qmul_s(poly, t);
    if (poly < 0) poly = 0;
    if (poly > 2 * ONE) poly = 2 * ONE;
    hi = s >> WB;
    lo = s & (ONE - 1);
    q = ((hi * hi) << WB) + 2 * hi * lo + ((lo * lo + HALF) >> WB);
    e = exp_neg_q30(q);
    m = qmul(poly, e);
    if (m > ONE) m = ONE;
    hm = (m + (64'd1 << (WB - FRAC))) >> (WB + 1 - FRAC);
    cdf = neg ? hm : ((64'd1 << FRAC) - hm);
    if (cdf > 64'h1FFFF) cdf = 64'h1FFFF;
    return cdf[16:0];
  endfunction

  // Fill the request queue: directed edges first, then mixed random values
  initial begin
    logic [19:0] dir[$] = '{20'h00000, 20'h00001, 20'hFFFFF, 20'h7FFFF, 20'h80000,
      20'h80001, 20'h10000, 20'hF0000, 20'h20000, 20'hE0000, 20'h08000, 20'hF8000,
      20'h5A827, 20'hA57D9, 20'h40000, 20'hC0000, 20'h55555, 20'hAAAAA, 20'h0FFFF,
      20'hF0001, 20'h00100};
    logic [19:0] v;
    foreach (dir[i]) pending_x = {pending_x, dir[i]};
    for (int i = 0; i < 450; i++) begin
      case ($urandom_range(0, 3))
        0: v = 20'($urandom);
        1: v = 20'($signed($urandom_range(0, 6 << 16)) *
             ($urandom_range(0, 1) ? 1 : -1));
        2: v = 20'($signed($urandom_range(0, 1 << 15)) *
             ($urandom_range(0, 1) ? 1 : -1));
        default: v = $urandom_range(0, 1) ? 20'(20'h7FFFF - $urandom_range(0, 15))
             : 20'(20'h80000 + $urandom_range(0, 15));
      endcase
      pending_x = {pending_x, v};
    end
  end

  int burst_left = 0;
  int gap_left = 0;
  int sent = 0;

  // Record requests taken at the rising edge
  always @(posedge clk) begin
    in_acc = rst_n && in_valid && in_ready;
    if (in_acc) begin
      expected_cdf = {expected_cdf, phi_of(in_x_value)};
      sent++;
    end
  end

  // Driver: bursts and gaps, one drain pause midway
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_acc) begin
        if (sent == 200 && !drained) drain_req = 1'b1;
        if (drain_req && expected_cdf.size() != 0) begin
          in_valid <= 1'b0;
        end else if (drain_req) begin
          drain_req = 1'b0;
          drained = 1'b1;
          in_valid <= 1'b0;
        end else if (pending_x.size() == 0) begin
          in_valid <= 1'b0;
          stim_done = 1'b1;
        end else if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_x_value <= pending_x.pop_front();
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold so the pipeline backs up
  int hold_cnt = 0;
  int rx_cycle = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      rx_cycle++;
      if (rx_cycle == 400) hold_cnt = 150;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if ((rx_cycle / 64) % 3 == 2) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_cdf.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result cdf=%0d", out_cdf_value);
      end else begin
        logic [16:0] want;
        want = expected_cdf.pop_front();
        if (want !== out_cdf_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cdf mismatch: expected %0d got %0d", want, out_cdf_value);
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    wait (stim_done && !in_valid && expected_cdf.size() == 0);
    repeat (LAT + 20) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end
endmodule
